// ----- sv/lsp2c_pkg.sv -----
// Shared types and constants of the laser scan polar-to-cartesian converter.
// No dependencies; the front, back and top files use these by scoped names.
`timescale 1ns / 1ps

package lsp2c_pkg;

    localparam int unsigned RANGE_W  = 24;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned POS_W    = 25;
    localparam int unsigned CFG_AW   = 3;
    localparam int unsigned GUARD    = 8;
    localparam int unsigned KINV_W   = 30;
    localparam int unsigned PROD_W   = RANGE_W + KINV_W;
    localparam int unsigned XW       = 35;
    localparam int unsigned ZW       = 33;
    localparam int unsigned TAB_LEN  = 24;

    localparam logic [KINV_W-1:0]  KINV        = 30'd652032875;
    localparam logic [RANGE_W-1:0] OUT_LIMIT   = 24'hFFFFFF;
    localparam logic [RANGE_W-1:0] MAX_RANGE_RST = 24'hFFFFFF;
    localparam logic [WORD_W-1:0]  QUARTER     = 32'h2000_0000;

    localparam logic [WORD_W-1:0] ATAN_TAB [TAB_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef enum logic [CFG_AW-1:0] {
        REG_START_ANGLE = 3'd0,
        REG_ANGLE_STEP  = 3'd1,
        REG_MIN_RANGE   = 3'd2,
        REG_MAX_RANGE   = 3'd3,
        REG_START_TIME  = 3'd4,
        REG_TIME_STEP   = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic               kept;
        logic [WORD_W-1:0]  stamp;
        logic               last;
    } t_tag;

    typedef struct packed {
        logic [RANGE_W-1:0] range;
        logic [WORD_W-1:0]  angle;
        t_tag               tag;
    } t_beam_item;

    typedef struct packed {
        logic                    kept;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [WORD_W-1:0]       stamp;
        logic                    last;
    } t_point;

endpackage

// ----- sv/lsp2c_fifo.sv -----
// Small register queue with registered pointers and fill count.
// Used between front and back and as the result queue; no dependencies.
`timescale 1ns / 1ps

module lsp2c_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;
    logic             wr_en, rd_en;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (rd_en) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({wr_en, rd_en})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- sv/lsp2c_front.sv -----
// Front part: configuration registers, beam angle and time accumulators,
// range window test. Depends on lsp2c_pkg.
`timescale 1ns / 1ps

module lsp2c_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lsp2c_pkg::CFG_AW-1:0]        i_cfg_addr,
    input  logic [lsp2c_pkg::WORD_W-1:0]        i_cfg_wdata,
    input  logic                                i_push,
    input  logic                                i_full,
    input  logic [lsp2c_pkg::RANGE_W-1:0]       i_range_sample,
    input  logic                                i_scan_last,
    output logic                                o_item_vld,
    output lsp2c_pkg::t_beam_item               o_item
);

    logic [lsp2c_pkg::WORD_W-1:0]  r_start_angle, r_angle_step, r_start_time, r_time_step;
    logic [lsp2c_pkg::RANGE_W-1:0] r_min_range, r_max_range;
    logic [lsp2c_pkg::WORD_W-1:0]  r_beam_angle, r_beam_time;
    logic [lsp2c_pkg::WORD_W-1:0]  n_beam_angle, n_beam_time;
    logic                          accept;

    assign accept     = i_push && !i_full;
    assign o_item_vld = accept;

    always_comb begin
        o_item.range     = i_range_sample;
        o_item.angle     = r_beam_angle;
        o_item.tag.kept  = (i_range_sample > r_min_range) && (i_range_sample < r_max_range);
        o_item.tag.stamp = r_beam_time;
        o_item.tag.last  = i_scan_last;
    end

    always_comb begin
        n_beam_angle = r_beam_angle;
        n_beam_time  = r_beam_time;
        if (accept) begin
            if (i_scan_last) begin
                n_beam_angle = r_start_angle;
                n_beam_time  = r_start_time;
            end else begin
                n_beam_angle = r_beam_angle + r_angle_step;
                n_beam_time  = r_beam_time + r_time_step;
            end
        end
        // a write of a start value also loads its accumulator
        if (i_cfg_we) begin
            if (i_cfg_addr == lsp2c_pkg::REG_START_ANGLE) begin
                n_beam_angle = i_cfg_wdata;
            end
            if (i_cfg_addr == lsp2c_pkg::REG_START_TIME) begin
                n_beam_time = i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_angle <= '0;
            r_angle_step  <= '0;
            r_min_range   <= '0;
            r_max_range   <= lsp2c_pkg::MAX_RANGE_RST;
            r_start_time  <= '0;
            r_time_step   <= '0;
            r_beam_angle  <= '0;
            r_beam_time   <= '0;
        end else begin
            r_beam_angle <= n_beam_angle;
            r_beam_time  <= n_beam_time;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    lsp2c_pkg::REG_START_ANGLE: r_start_angle <= i_cfg_wdata;
                    lsp2c_pkg::REG_ANGLE_STEP:  r_angle_step  <= i_cfg_wdata;
                    lsp2c_pkg::REG_MIN_RANGE:
                        r_min_range <= i_cfg_wdata[lsp2c_pkg::RANGE_W-1:0];
                    lsp2c_pkg::REG_MAX_RANGE:
                        r_max_range <= i_cfg_wdata[lsp2c_pkg::RANGE_W-1:0];
                    lsp2c_pkg::REG_START_TIME:  r_start_time  <= i_cfg_wdata;
                    lsp2c_pkg::REG_TIME_STEP:   r_time_step   <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

endmodule

// ----- sv/lsp2c_back.sv -----
// Back part: gain pre-scale multiply, quadrant pre-rotation, unrolled
// CORDIC pipeline, rounding and saturation. Depends on lsp2c_pkg.
`timescale 1ns / 1ps

module lsp2c_back #(
    parameter int unsigned CORDIC_STAGES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_item_vld,
    input  lsp2c_pkg::t_beam_item i_item,
    output logic                  o_take,
    input  logic                  i_out_full,
    output logic                  o_point_vld,
    output lsp2c_pkg::t_point     o_point
);

    localparam int unsigned XW = lsp2c_pkg::XW;
    localparam int unsigned ZW = lsp2c_pkg::ZW;
    localparam int unsigned N  = (CORDIC_STAGES > lsp2c_pkg::TAB_LEN) ?
                                 lsp2c_pkg::TAB_LEN : CORDIC_STAGES;

    logic advance;

    // multiply stage
    logic                          r_a_vld;
    logic [lsp2c_pkg::PROD_W-1:0]  r_a_prod;
    logic [lsp2c_pkg::WORD_W-1:0]  r_a_angle;
    lsp2c_pkg::t_tag               r_a_tag;

    // rotation stages: index 0 after pre-rotation, index i+1 after micro-rotation i
    logic                    r_v   [N+1];
    logic signed [XW-1:0]    r_x   [N+1];
    logic signed [XW-1:0]    r_y   [N+1];
    logic signed [ZW-1:0]    r_z   [N+1];
    lsp2c_pkg::t_tag         r_tag [N+1];

    // output stage
    logic              r_f_vld;
    lsp2c_pkg::t_point r_f_point;

    assign advance     = !(r_f_vld && i_out_full);
    assign o_take      = advance && i_item_vld;
    assign o_point_vld = r_f_vld && !i_out_full;
    assign o_point     = r_f_point;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (advance) begin
            r_a_vld <= i_item_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_a_prod  <= lsp2c_pkg::PROD_W'(i_item.range) * lsp2c_pkg::PROD_W'(lsp2c_pkg::KINV);
            r_a_angle <= i_item.angle;
            r_a_tag   <= i_item.tag;
        end
    end

    // quadrant removal
    logic [lsp2c_pkg::PROD_W:0]   prod_rnd;
    logic [lsp2c_pkg::WORD_W-1:0] scaled;
    logic [lsp2c_pkg::WORD_W-1:0] ang_off;
    logic [1:0]                   quad;
    logic [lsp2c_pkg::WORD_W-1:0] resid;
    logic signed [XW-1:0]         gain;
    logic signed [XW-1:0]         x_init, y_init;

    always_comb begin
        prod_rnd = {1'b0, r_a_prod} + (lsp2c_pkg::PROD_W+1)'(1 << (22 - 1));
        scaled   = prod_rnd[22 +: lsp2c_pkg::WORD_W];
        ang_off  = r_a_angle + lsp2c_pkg::QUARTER;
        quad     = ang_off[lsp2c_pkg::WORD_W-1 -: 2];
        resid    = r_a_angle - {quad, 30'd0};
        gain     = signed'(XW'(scaled));
        case (quad)
            2'd0:    begin x_init = gain;  y_init = '0;    end
            2'd1:    begin x_init = '0;    y_init = gain;  end
            2'd2:    begin x_init = -gain; y_init = '0;    end
            default: begin x_init = '0;    y_init = -gain; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (advance) begin
            r_v[0] <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_x[0]   <= x_init;
            r_y[0]   <= y_init;
            r_z[0]   <= ZW'(signed'(resid));
            r_tag[0] <= r_a_tag;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_stage
        localparam logic signed [ZW-1:0] ANG = ZW'(lsp2c_pkg::ATAN_TAB[i]);
        logic signed [XW-1:0] dx, dy;

        assign dx = r_y[i] >>> i;
        assign dy = r_x[i] >>> i;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (advance) begin
                r_v[i+1] <= r_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (advance) begin
                if (!r_z[i][ZW-1]) begin
                    r_x[i+1] <= r_x[i] - dx;
                    r_y[i+1] <= r_y[i] + dy;
                    r_z[i+1] <= r_z[i] - ANG;
                end else begin
                    r_x[i+1] <= r_x[i] + dx;
                    r_y[i+1] <= r_y[i] - dy;
                    r_z[i+1] <= r_z[i] + ANG;
                end
                r_tag[i+1] <= r_tag[i];
            end
        end
    end

    // drop guard bits with round half up, then saturate
    localparam logic signed [XW-1:0] LIM  = signed'(XW'(lsp2c_pkg::OUT_LIMIT));
    localparam logic signed [XW-1:0] HALF = signed'(XW'(1 << (lsp2c_pkg::GUARD - 1)));

    logic signed [XW-1:0]                x_rnd, y_rnd;
    logic signed [lsp2c_pkg::POS_W-1:0]  x_sat, y_sat;

    always_comb begin
        x_rnd = (r_x[N] + HALF) >>> lsp2c_pkg::GUARD;
        y_rnd = (r_y[N] + HALF) >>> lsp2c_pkg::GUARD;
        if (x_rnd > LIM) begin
            x_sat = lsp2c_pkg::POS_W'(LIM);
        end else if (x_rnd < -LIM) begin
            x_sat = lsp2c_pkg::POS_W'(-LIM);
        end else begin
            x_sat = x_rnd[lsp2c_pkg::POS_W-1:0];
        end
        if (y_rnd > LIM) begin
            y_sat = lsp2c_pkg::POS_W'(LIM);
        end else if (y_rnd < -LIM) begin
            y_sat = lsp2c_pkg::POS_W'(-LIM);
        end else begin
            y_sat = y_rnd[lsp2c_pkg::POS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (advance) begin
            r_f_vld <= r_v[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_f_point.kept  <= r_tag[N].kept;
            r_f_point.x     <= r_tag[N].kept ? x_sat : '0;
            r_f_point.y     <= r_tag[N].kept ? y_sat : '0;
            r_f_point.stamp <= r_tag[N].stamp;
            r_f_point.last  <= r_tag[N].last;
        end
    end

endmodule

// ----- sv/laser_scan_polar_to_cartesian_top.sv -----
// Top level of the laser scan polar-to-cartesian converter.
// Depends on lsp2c_pkg, lsp2c_front, lsp2c_fifo and lsp2c_back.
//
// Usage:
//   Input queue: drive range_sample and scan_last with push high; the sample
//   transfers at a rising edge where push is high and full is low.
//   Result queue: while empty is low the oldest point sits on the o_ ports;
//   it transfers at a rising edge where pop is high and empty is low.
//   Configuration: a write with i_cfg_we high stores i_cfg_wdata into the
//   register at i_cfg_addr in the same edge; writes of start angle or start
//   time also load the running angle or time. Write only while idle.
//   Path: input queue, multiply, pre-rotation, CORDIC, output reg, result queue.
//   Throughput: one sample per cycle unless stalled, set by the unrolled
//   CORDIC pipeline with one micro-rotation per stage.
//   Stalls: when the result queue fills, the back pipeline holds; the
//   four-entry queue behind the front then fills and raises full.
//   Reset: synchronous, clears all queues and pipeline valids and returns
//   the registers and accumulators to their reset values.
`timescale 1ns / 1ps

module laser_scan_polar_to_cartesian_top #(
    parameter int unsigned CORDIC_STAGES = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [lsp2c_pkg::CFG_AW-1:0]         i_cfg_addr,
    input  logic [lsp2c_pkg::WORD_W-1:0]         i_cfg_wdata,
    input  logic                                 push,
    output logic                                 full,
    input  logic [lsp2c_pkg::RANGE_W-1:0]        i_range_sample,
    input  logic                                 i_scan_last,
    input  logic                                 pop,
    output logic                                 empty,
    output logic                                 o_point_kept,
    output logic signed [lsp2c_pkg::POS_W-1:0]   o_x_pos,
    output logic signed [lsp2c_pkg::POS_W-1:0]   o_y_pos,
    output logic [lsp2c_pkg::WORD_W-1:0]         o_stamp,
    output logic                                 o_scan_done
);

    localparam int unsigned MID_DEPTH = 4;
    localparam int unsigned OUT_DEPTH = 2;
    localparam int unsigned ITEM_W    = $bits(lsp2c_pkg::t_beam_item);
    localparam int unsigned POINT_W   = $bits(lsp2c_pkg::t_point);

    logic                  item_vld;
    lsp2c_pkg::t_beam_item item_in, item_mid;
    logic                  mid_empty, take;
    logic                  out_full, point_vld;
    lsp2c_pkg::t_point     point_in, point_out;

    lsp2c_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_push         (push),
        .i_full         (full),
        .i_range_sample (i_range_sample),
        .i_scan_last    (i_scan_last),
        .o_item_vld     (item_vld),
        .o_item         (item_in)
    );

    lsp2c_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (item_vld),
        .i_data  (item_in),
        .o_full  (full),
        .i_pop   (take),
        .o_data  (item_mid),
        .o_empty (mid_empty)
    );

    lsp2c_back #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item_vld  (!mid_empty),
        .i_item      (item_mid),
        .o_take      (take),
        .i_out_full  (out_full),
        .o_point_vld (point_vld),
        .o_point     (point_in)
    );

    lsp2c_fifo #(
        .WIDTH (POINT_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (point_vld),
        .i_data  (point_in),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (point_out),
        .o_empty (empty)
    );

    assign o_point_kept = point_out.kept;
    assign o_x_pos      = point_out.x;
    assign o_y_pos      = point_out.y;
    assign o_stamp      = point_out.stamp;
    assign o_scan_done  = point_out.last;

endmodule
